// ===== sv/ntl_pkg.sv =====
`default_nettype none

package ntl_pkg;

    localparam int NODE_W  = 32;
    localparam int STAMP_W = 32;
    localparam int SLOT_W  = 6;
    localparam int USED_W  = 7;
    localparam int EVICT_W = 32;

    // stamps at this value are never picked as a victim
    localparam logic [STAMP_W-1:0] STAMP_NONE = '1;

    typedef enum logic [1:0] {
        OP_GET   = 2'd0,
        OP_FIND  = 2'd1,
        OP_FAV   = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE
    } t_state;

    // one table slot as stored in memory
    typedef struct packed {
        logic [NODE_W-1:0]  node;
        logic [STAMP_W-1:0] seen;
        logic               fav;
    } t_entry;

    typedef struct packed {
        logic               found;
        logic [SLOT_W-1:0]  slot_index;
        logic               inserted;
        logic               did_evict;
        logic [STAMP_W-1:0] seen_stamp;
        logic [USED_W-1:0]  entries_used;
        logic [EVICT_W-1:0] evictions_total;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/ntl_if.sv =====
`default_nettype none

interface ntl_cfg_if import ntl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] own_node_number;

    modport source (output valid, output own_node_number, input ready);
    modport sink   (input valid, input own_node_number, output ready);
endinterface

interface ntl_req_if import ntl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [NODE_W-1:0] node_number;
    logic              favourite_value;

    modport source (output valid, output opcode, output node_number,
                    output favourite_value, input ready);
    modport sink   (input valid, input opcode, input node_number,
                    input favourite_value, output ready);
endinterface

interface ntl_res_if import ntl_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               found;
    logic [SLOT_W-1:0]  slot_index;
    logic               inserted;
    logic               did_evict;
    logic [STAMP_W-1:0] seen_stamp;
    logic [USED_W-1:0]  entries_used;
    logic [EVICT_W-1:0] evictions_total;

    modport source (output valid, output found, output slot_index, output inserted,
                    output did_evict, output seen_stamp, output entries_used,
                    output evictions_total, input ready);
    modport sink   (input valid, input found, input slot_index, input inserted,
                    input did_evict, input seen_stamp, input entries_used,
                    input evictions_total, output ready);
endinterface

`default_nettype wire

// ===== sv/ntl_ram.sv =====
`default_nettype none

module ntl_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== sv/node_table_lru_exclusion.sv =====
`default_nettype none

// channel  | dir | handshake     | payload
// ---------+-----+---------------+----------------------------------------------
// i_cfg    | in  | valid / ready | own_node_number
// i_req    | in  | valid / ready | opcode, node_number, favourite_value
// o_res    | out | valid / ready | found, slot_index, inserted, did_evict,
//          |     |               | seen_stamp, entries_used, evictions_total
//
// a get, find or set-favourite request is accepted, then reads every slot from memory in
// turn through the registered read port, then writes back once the output register is free
// a clear request goes straight from accept to write-back, it never touches the memory
// the single memory read port sets the rate; one request is in flight at a time
// reset is synchronous and active low, no clearing pass: valid slots are 0..count-1
// a stalled result holds in the output register; the next request may be taken meanwhile

module node_table_lru_exclusion import ntl_pkg::*; #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ntl_cfg_if.sink  i_cfg,
    ntl_req_if.sink  i_req,
    ntl_res_if.source o_res
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);
    localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

    // control state
    t_state             r_state, n_state;
    logic               r_o_valid, n_o_valid;
    logic [CW-1:0]      r_cnt, n_cnt;          // next slot to read
    logic               r_dvld, n_dvld;        // read data is present this cycle
    logic [AW-1:0]      r_didx, n_didx;        // slot of that read data
    logic [CW-1:0]      r_count, n_count;      // valid slots, always the lowest ones
    logic [STAMP_W-1:0] r_clock, n_clock;
    logic [EVICT_W-1:0] r_evict, n_evict;
    logic [NODE_W-1:0]  r_own;

    // request under work and scan results
    t_op                r_op, n_op;
    logic [NODE_W-1:0]  r_num, n_num;
    logic               r_fav_in, n_fav_in;
    logic               r_hit, n_hit;
    logic [AW-1:0]      r_slot, n_slot;
    logic [STAMP_W-1:0] r_hit_stamp, n_hit_stamp;
    logic               r_hit_fav, n_hit_fav;
    logic [STAMP_W-1:0] r_best, n_best;
    logic [AW-1:0]      r_vic, n_vic;
    t_result            r_res, n_res;

    // memory port
    logic               w_rd_en;
    t_entry             w_rd_data;
    logic               w_wr_en;
    logic [AW-1:0]      w_wr_addr;
    t_entry             w_wr_data;

    logic [STAMP_W-1:0]    w_new_stamp;
    logic                  w_held;
    logic [STAMP_W-1:0]    w_stamp_out;

    ntl_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_cnt[AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == S_IDLE);
    assign w_new_stamp = r_clock + STAMP_W'(1);

    always_comb begin
        n_state     = r_state;
        n_o_valid   = r_o_valid;
        n_cnt       = r_cnt;
        n_dvld      = 1'b0;
        n_didx      = r_cnt[AW-1:0];
        n_count     = r_count;
        n_clock     = r_clock;
        n_evict     = r_evict;
        n_op        = r_op;
        n_num       = r_num;
        n_fav_in    = r_fav_in;
        n_hit       = r_hit;
        n_slot      = r_slot;
        n_hit_stamp = r_hit_stamp;
        n_hit_fav   = r_hit_fav;
        n_best      = r_best;
        n_vic       = r_vic;
        n_res       = r_res;
        w_rd_en     = 1'b0;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_slot;
        w_wr_data   = '{node: r_num, seen: r_hit_stamp, fav: r_hit_fav};
        w_held      = 1'b0;
        w_stamp_out = '0;

        // result taken downstream
        if (r_o_valid && o_res.ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op     = t_op'(i_req.opcode);
                    n_num    = i_req.node_number;
                    n_fav_in = i_req.favourite_value;
                    n_hit    = 1'b0;
                    n_best   = STAMP_NONE;
                    n_vic    = '0;
                    n_cnt    = '0;
                    n_state  = (t_op'(i_req.opcode) == OP_CLEAR) ? S_WRITE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cnt < FULL) begin
                    w_rd_en = 1'b1;
                    n_cnt   = r_cnt + CW'(1);
                end
                n_dvld = w_rd_en;
                if (r_dvld) begin
                    // lookup among valid slots
                    if (({1'b0, r_didx} < r_count) && (w_rd_data.node == r_num) && !r_hit) begin
                        n_hit       = 1'b1;
                        n_slot      = r_didx;
                        n_hit_stamp = w_rd_data.seen;
                        n_hit_fav   = w_rd_data.fav;
                    end
                    // victim search, only used when every slot is valid
                    if ((w_rd_data.node != r_own) && !w_rd_data.fav &&
                        (w_rd_data.seen < r_best)) begin
                        n_best = w_rd_data.seen;
                        n_vic  = r_didx;
                    end
                    if (r_didx == LAST) begin
                        n_state = S_WRITE;
                    end
                end
            end
            S_WRITE: begin
                if (!r_o_valid || o_res.ready) begin
                    n_res.inserted  = 1'b0;
                    n_res.did_evict = 1'b0;
                    case (r_op)
                        OP_CLEAR: begin
                            n_count = '0;
                            n_clock = '0;
                        end
                        OP_GET: begin
                            n_clock     = w_new_stamp;
                            w_held      = 1'b1;
                            w_stamp_out = w_new_stamp;
                            w_wr_en     = 1'b1;
                            w_wr_data   = '{node: r_num, seen: w_new_stamp, fav: r_hit_fav};
                            if (!r_hit) begin
                                n_res.inserted = 1'b1;
                                w_wr_data.fav  = 1'b0;
                                if (r_count < FULL) begin
                                    w_wr_addr = r_count[AW-1:0];
                                    n_count   = r_count + CW'(1);
                                end else begin
                                    w_wr_addr       = r_vic;
                                    n_evict         = r_evict + EVICT_W'(1);
                                    n_res.did_evict = 1'b1;
                                end
                            end
                        end
                        OP_FIND: begin
                            w_held      = r_hit;
                            w_stamp_out = r_hit ? r_hit_stamp : '0;
                        end
                        OP_FAV: begin
                            w_held        = r_hit;
                            w_stamp_out   = r_hit ? r_hit_stamp : '0;
                            w_wr_en       = r_hit;
                            w_wr_data.fav = r_fav_in;
                        end
                        default: begin
                        end
                    endcase
                    n_res.found           = r_hit;
                    n_res.slot_index      = w_held ? SLOT_W'(w_wr_addr) : '0;
                    n_res.seen_stamp      = w_stamp_out;
                    n_res.entries_used    = USED_W'(n_count);
                    n_res.evictions_total = n_evict;
                    n_o_valid             = 1'b1;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_dvld    <= 1'b0;
            r_count   <= '0;
            r_clock   <= '0;
            r_evict   <= '0;
            r_own     <= '0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            r_dvld    <= n_dvld;
            r_count   <= n_count;
            r_clock   <= n_clock;
            r_evict   <= n_evict;
            if (i_cfg.valid) begin
                r_own <= i_cfg.own_node_number;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_cnt       <= n_cnt;
        r_didx      <= n_didx;
        r_op        <= n_op;
        r_num       <= n_num;
        r_fav_in    <= n_fav_in;
        r_hit       <= n_hit;
        r_slot      <= n_slot;
        r_hit_stamp <= n_hit_stamp;
        r_hit_fav   <= n_hit_fav;
        r_best      <= n_best;
        r_vic       <= n_vic;
        r_res       <= n_res;
    end

    assign o_res.valid           = r_o_valid;
    assign o_res.found           = r_res.found;
    assign o_res.slot_index      = r_res.slot_index;
    assign o_res.inserted        = r_res.inserted;
    assign o_res.did_evict       = r_res.did_evict;
    assign o_res.seen_stamp      = r_res.seen_stamp;
    assign o_res.entries_used    = r_res.entries_used;
    assign o_res.evictions_total = r_res.evictions_total;

`ifndef SYNTH
    // fill count never passes the table size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("fill count beyond table size");

    // an eviction is always a fresh insert of a missing node
    a_evict_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.did_evict) |-> (o_res.inserted && !o_res.found))
        else $error("eviction without insert");

    // the memory is only written in the write-back cycle
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (r_state == S_WRITE))
        else $error("memory write outside write-back");

    // the recency clock only steps by one or restarts at zero
    a_clock_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_clock) |-> ((r_clock == $past(r_clock) + STAMP_W'(1)) || (r_clock == '0)))
        else $error("recency clock jumped");
`endif

endmodule

`default_nettype wire

// ===== sim/node_table_lru_exclusion_chk.sv =====
`timescale 1ns / 1ps

module node_table_lru_exclusion_chk import ntl_pkg::*; #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ntl_cfg_if   i_cfg,
    ntl_req_if   i_req,
    ntl_res_if   i_res,
    output int   o_pending,
    output int   o_fail_count
);

    // shadow copy of the node table
    logic               tbl_valid [TABLE_ENTRIES];
    logic [NODE_W-1:0]  tbl_node  [TABLE_ENTRIES];
    logic               tbl_fav   [TABLE_ENTRIES];
    logic [STAMP_W-1:0] tbl_seen  [TABLE_ENTRIES];
    logic [STAMP_W-1:0] recency_now;
    logic [EVICT_W-1:0] eviction_tally;
    int                 used_slots;
    logic [NODE_W-1:0]  own_node;

    t_result expected_results[$];
    int      fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string what);
        if (fail_count < 100)
            $display("%0t: mismatch: %s", $time, what);
        fail_count++;
    endtask

    // one request against the shadow table, queues the result it must give
    task automatic apply_request(input t_op op, input logic [NODE_W-1:0] num,
                                 input logic fav);
        t_result            r;
        int                 i;
        int                 slot;
        int                 victim;
        logic [STAMP_W-1:0] oldest;
        r    = '0;
        slot = -1;
        if (op == OP_CLEAR) begin
            for (i = 0; i < TABLE_ENTRIES; i++) begin
                tbl_valid[i] = 1'b0;
                tbl_fav[i]   = 1'b0;
            end
            recency_now = '0;
            used_slots  = 0;
        end else begin
            for (i = 0; i < TABLE_ENTRIES; i++)
                if (slot < 0 && tbl_valid[i] && tbl_node[i] == num)
                    slot = i;
            r.found = (slot >= 0);
            if (op == OP_GET) begin
                if (slot < 0) begin
                    for (i = 0; i < TABLE_ENTRIES; i++)
                        if (slot < 0 && !tbl_valid[i])
                            slot = i;
                    if (slot < 0) begin
                        // full: oldest stamp among entries that are not pinned
                        oldest = STAMP_NONE;
                        victim = 0;
                        for (i = 0; i < TABLE_ENTRIES; i++)
                            if (tbl_node[i] != own_node && !tbl_fav[i] &&
                                tbl_seen[i] < oldest) begin
                                oldest = tbl_seen[i];
                                victim = i;
                            end
                        slot = victim;
                        eviction_tally++;
                        r.did_evict = 1'b1;
                    end else begin
                        used_slots++;
                    end
                    tbl_valid[slot] = 1'b1;
                    tbl_node[slot]  = num;
                    tbl_fav[slot]   = 1'b0;
                    r.inserted      = 1'b1;
                end
                recency_now++;
                tbl_seen[slot] = recency_now;
            end else if (op == OP_FAV && slot >= 0) begin
                tbl_fav[slot] = fav;
            end
            if (slot >= 0) begin
                r.slot_index = SLOT_W'(slot);
                r.seen_stamp = tbl_seen[slot];
            end
        end
        r.entries_used    = USED_W'(used_slots);
        r.evictions_total = eviction_tally;
        expected_results.push_back(r);
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result with nothing outstanding, slot %0d",
                                      got.slot_index));
            return;
        end
        want = expected_results.pop_front();
        if (got.found !== want.found)
            report_mismatch($sformatf("found %0d, want %0d", got.found, want.found));
        if (got.slot_index !== want.slot_index)
            report_mismatch($sformatf("slot_index %0d, want %0d",
                                      got.slot_index, want.slot_index));
        if (got.inserted !== want.inserted)
            report_mismatch($sformatf("inserted %0d, want %0d",
                                      got.inserted, want.inserted));
        if (got.did_evict !== want.did_evict)
            report_mismatch($sformatf("did_evict %0d, want %0d",
                                      got.did_evict, want.did_evict));
        if (got.seen_stamp !== want.seen_stamp)
            report_mismatch($sformatf("seen_stamp %h, want %h",
                                      got.seen_stamp, want.seen_stamp));
        if (got.entries_used !== want.entries_used)
            report_mismatch($sformatf("entries_used %0d, want %0d",
                                      got.entries_used, want.entries_used));
        if (got.evictions_total !== want.evictions_total)
            report_mismatch($sformatf("evictions_total %0d, want %0d",
                                      got.evictions_total, want.evictions_total));
    endtask

    always @(posedge i_clk) begin
        t_result got;
        int      i;
        if (!i_rst_n) begin
            for (i = 0; i < TABLE_ENTRIES; i++) begin
                tbl_valid[i] = 1'b0;
                tbl_fav[i]   = 1'b0;
                tbl_node[i]  = '0;
                tbl_seen[i]  = '0;
            end
            recency_now    = '0;
            eviction_tally = '0;
            used_slots     = 0;
            own_node       = '0;
            expected_results.delete();
        end else begin
            if ($isunknown(i_res.valid))
                report_mismatch("result valid is unknown");
            if (i_res.valid && i_res.ready) begin
                got.found           = i_res.found;
                got.slot_index      = i_res.slot_index;
                got.inserted        = i_res.inserted;
                got.did_evict       = i_res.did_evict;
                got.seen_stamp      = i_res.seen_stamp;
                got.entries_used    = i_res.entries_used;
                got.evictions_total = i_res.evictions_total;
                check_result(got);
            end
            if (i_cfg.valid && i_cfg.ready)
                own_node = i_cfg.own_node_number;
            if (i_req.valid && i_req.ready)
                apply_request(t_op'(i_req.opcode), i_req.node_number,
                              i_req.favourite_value);
        end
        o_pending <= expected_results.size();
    end

endmodule

// ===== sim/node_table_lru_exclusion_tb.sv =====
`timescale 1ns / 1ps

module node_table_lru_exclusion_tb;

    import ntl_pkg::*;

    localparam int TABLE_ENTRIES = 64;
    // stop offering random requests once this many have gone in
    localparam int REQUEST_TARGET = 1100;
    // one long result-side hold-off, enough for the block to back up
    localparam int HOLD_CYCLES = 600;
    // a get, find or set-favourite walks every slot
    localparam int REQ_CYCLES = TABLE_ENTRIES + 3;

    logic clk = 1'b0;
    logic rst_n;

    ntl_cfg_if cfg_if ();
    ntl_req_if req_if ();
    ntl_res_if res_if ();

    int pending;
    int fail_count;
    int requests_sent = 0;

    // stimulus-side knobs read by the result-side driver
    logic hold_request = 1'b0;
    logic calm = 1'b0;
    bit   hold_served = 1'b0;

    // node numbers of the current phase, all distinct
    logic [NODE_W-1:0] pool [0:127];

    node_table_lru_exclusion #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) uut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_cfg  (cfg_if),
        .i_req  (req_if),
        .o_res  (res_if)
    );

    node_table_lru_exclusion_chk #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg       (cfg_if),
        .i_req       (req_if),
        .i_res       (res_if),
        .o_pending   (pending),
        .o_fail_count(fail_count)
    );

    always #5 clk = ~clk;

    // hard stop in case the block hangs
    initial begin
        #10000000;
        $display("FAIL node_table_lru_exclusion");
        $finish;
    end

    // result side: random back-pressure, one long hold-off on request
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request && !hold_served) begin
                hold_served = 1'b1;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                res_if.ready <= calm || ($urandom_range(0, 99) >= 14);
            end
        end
    end

    // offer one request, sometimes after a gap, and wait for the handshake
    // valid stays high into the next request when there is no gap
    task automatic send_req(input t_op op, input logic [NODE_W-1:0] num,
                            input logic fav);
        int gap;
        if (!calm && $urandom_range(0, 99) < 14) begin
            // mostly short gaps, now and then one longer than a whole request
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 150)
                                              : $urandom_range(1, 3);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid           <= 1'b1;
        req_if.opcode          <= op;
        req_if.node_number     <= num;
        req_if.favourite_value <= fav;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        requests_sent++;
    endtask

    // only written while the block is idle
    task automatic write_own(input logic [NODE_W-1:0] value);
        cfg_if.valid           <= 1'b1;
        cfg_if.own_node_number <= value;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // sender stops until every outstanding result has come back
    task automatic drain();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // odd stride keeps the numbers distinct
    task automatic fill_pool();
        logic [NODE_W-1:0] base;
        logic [NODE_W-1:0] stride;
        int                k;
        base   = $urandom;
        stride = $urandom | 32'd1;
        for (k = 0; k < 128; k++)
            pool[k] = base + NODE_W'(k) * stride;
    endtask

    // own number: an extreme, a node of the phase, or anything
    function automatic logic [NODE_W-1:0] pick_own(input int span);
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return pool[$urandom_range(0, span - 1)];
            default: return $urandom;
        endcase
    endfunction

    // mixed traffic on a pool that may or may not overflow the table
    task automatic churn_phase(input int span, input int count);
        int                n;
        int                pick;
        logic [NODE_W-1:0] num;
        fill_pool();
        write_own(pick_own(span));
        for (n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            num  = pool[$urandom_range(0, span - 1)];
            if (pick < 60)
                send_req(OP_GET, num, 1'($urandom_range(0, 1)));
            else if (pick < 75)
                send_req(OP_FIND, num, 1'($urandom_range(0, 1)));
            else if (pick < 91)
                send_req(OP_FAV, num, 1'($urandom_range(0, 1)));
            else if (pick < 92)
                send_req(OP_CLEAR, num, 1'($urandom_range(0, 1)));
            else
                // noise: any opcode on any number
                send_req(t_op'($urandom_range(0, 3)), $urandom,
                         1'($urandom_range(0, 1)));
        end
        drain();
    endtask

    // fill the table, pin part or all of it, then force evictions
    // with everything pinned the victim falls back to slot 0
    task automatic pin_phase(input int pin_pct);
        int n;
        int pick;
        fill_pool();
        write_own(($urandom_range(0, 1) == 1) ? pool[$urandom_range(0, 63)]
                                              : pick_own(64));
        send_req(OP_CLEAR, $urandom, 1'($urandom_range(0, 1)));
        for (n = 0; n < TABLE_ENTRIES; n++)
            send_req(OP_GET, pool[n], 1'($urandom_range(0, 1)));
        for (n = 0; n < TABLE_ENTRIES; n++)
            if ($urandom_range(0, 99) < pin_pct)
                send_req(OP_FAV, pool[n], 1'b1);
        for (n = 0; n < 24; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_req(OP_GET, pool[64 + $urandom_range(0, 31)], 1'b0);
            else if (pick < 75)
                send_req(OP_GET, pool[$urandom_range(0, 63)], 1'b0);
            else if (pick < 90)
                send_req(OP_FIND, pool[$urandom_range(0, 95)], 1'b0);
            else
                send_req(OP_FAV, pool[$urandom_range(0, 95)],
                         1'($urandom_range(0, 1)));
        end
        drain();
    endtask

    initial begin
        int phase;
        int pct;
        rst_n                  <= 1'b0;
        cfg_if.valid           <= 1'b0;
        cfg_if.own_node_number <= '0;
        req_if.valid           <= 1'b0;
        req_if.opcode          <= OP_GET;
        req_if.node_number     <= '0;
        req_if.favourite_value <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: own node is zero
        write_own('0);
        send_req(OP_FIND, '0, 1'b0);               // lookup on an empty table
        send_req(OP_FAV, '1, 1'b1);                // set favourite on a missing node
        send_req(OP_GET, '0, 1'b0);                // insert the own node into slot 0
        send_req(OP_GET, '1, 1'b1);                // insert all-ones into slot 1
        send_req(OP_GET, '0, 1'b0);                // hit restamps
        send_req(OP_FIND, '1, 1'b0);               // hit without touching
        send_req(OP_FAV, '1, 1'b1);
        send_req(OP_FAV, '1, 1'b0);
        send_req(OP_FAV, '0, 1'b1);
        send_req(OP_GET, 32'h5a5a_a5a5, 1'b0);
        send_req(OP_CLEAR, '1, 1'b1);              // clear keeps eviction count
        send_req(OP_FIND, '0, 1'b0);               // gone after clear
        send_req(OP_GET, 32'h8000_0001, 1'b0);     // clock restarts from zero
        drain();

        // directed: own node is all ones
        write_own('1);
        send_req(OP_GET, '1, 1'b0);
        send_req(OP_FIND, '0, 1'b0);
        send_req(OP_FAV, 32'h8000_0001, 1'b1);
        send_req(OP_CLEAR, 32'h7fff_fffe, 1'b0);
        send_req(OP_GET, '0, 1'b1);
        drain();

        // random phases, each ends with every result back
        phase = 0;
        while (requests_sent < REQUEST_TARGET) begin
            if (phase == 0) begin
                // results held off long enough to back up the block
                hold_request <= 1'b1;
                churn_phase(64, 120);
            end else if (phase == 1) begin
                pin_phase(100);
            end else if (phase == 2) begin
                // a stretch with no idling on either side
                calm <= 1'b1;
                churn_phase(80, 120);
                calm <= 1'b0;
            end else if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 2))
                    0:       pct = 100;
                    1:       pct = 85;
                    default: pct = 40;
                endcase
                pin_phase(pct);
            end else begin
                churn_phase($urandom_range(40, 90), 120);
            end
            phase++;
        end

        // catch any stray result after the last one
        repeat (2 * REQ_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS node_table_lru_exclusion");
        else
            $display("FAIL node_table_lru_exclusion");
        $finish;
    end

endmodule
